@@ design/tmp_pkg.sv @@
`default_nettype none
package tmp_pkg;

  localparam int INDEX_BITS   = 31;
  localparam int MODULUS_BITS = 31;
  localparam int FIELD_BITS   = 31;
  localparam int IDX_W        = (INDEX_BITS < FIELD_BITS) ? INDEX_BITS : FIELD_BITS;
  localparam int CFG_IDX_BITS = 2;
  localparam int MODULUS_RST  = 1000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODULUS,
    REG_FIRST,
    REG_SECOND,
    REG_THIRD
  } cfg_reg_e;

  typedef logic [MODULUS_BITS-1:0] elem_t;
  typedef logic [2:0][MODULUS_BITS-1:0] xvec_t;
  typedef logic [2:0][FIELD_BITS-1:0] yvec_t;
  typedef logic [2:0][2:0][MODULUS_BITS-1:0] mat_t;

  function automatic mat_t identity_mat();
    mat_t r;
    r = '0;
    r[0][0] = elem_t'(1);
    r[1][1] = elem_t'(1);
    r[2][2] = elem_t'(1);
    return r;
  endfunction

  function automatic mat_t companion_mat();
    mat_t r;
    r = '0;
    r[0][0] = elem_t'(1);
    r[0][1] = elem_t'(1);
    r[0][2] = elem_t'(1);
    r[1][0] = elem_t'(1);
    r[2][1] = elem_t'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/tmp_dot.sv @@
`default_nettype none
module tmp_dot (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [tmp_pkg::MODULUS_BITS-1:0] m_i,
  input  wire tmp_pkg::xvec_t                 x_i,
  input  wire tmp_pkg::yvec_t                 y_i,
  output logic                                done_o,
  output logic [tmp_pkg::MODULUS_BITS-1:0]    res_o
);

  localparam int MB = tmp_pkg::MODULUS_BITS;
  localparam int FB = tmp_pkg::FIELD_BITS;
  localparam int CW = $clog2(FB);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_ADD
  } state_e;

  state_e          state_q;
  logic [1:0]      pair_q;
  logic [CW-1:0]   cnt_q;
  logic [FB-1:0]   ys_q;
  logic [MB-1:0]   r_q, r_d;
  logic [MB-1:0]   sum_q, sum_d;
  logic            done_q;

  logic [MB+1:0]   t0, t1, t2;
  logic [MB:0]     s0;
  logic            ge1, ge2;

  // shift-and-add step: r = 2r + bit*x, kept below m
  always_comb begin
    t0 = {1'b0, r_q, 1'b0} + (ys_q[FB-1] ? {2'b00, x_i[pair_q]} : '0);
    t1 = t0 - {2'b00, m_i};
    t2 = t0 - {1'b0, m_i, 1'b0};
    ge1 = t0 >= {2'b00, m_i};
    ge2 = t0 >= {1'b0, m_i, 1'b0};
    if (ge2) begin
      r_d = t2[MB-1:0];
    end else if (ge1) begin
      r_d = t1[MB-1:0];
    end else begin
      r_d = t0[MB-1:0];
    end
    s0 = {1'b0, sum_q} + {1'b0, r_q};
    if (s0 >= {1'b0, m_i}) begin
      sum_d = MB'(s0 - {1'b0, m_i});
    end else begin
      sum_d = s0[MB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      pair_q  <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_SHIFT;
            pair_q  <= '0;
            cnt_q   <= CW'(FB - 1);
            ys_q    <= y_i[0];
            r_q     <= '0;
            sum_q   <= '0;
          end
        end
        S_SHIFT: begin
          r_q  <= r_d;
          ys_q <= {ys_q[FB-2:0], 1'b0};
          if (cnt_q == '0) begin
            state_q <= S_ADD;
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        S_ADD: begin
          sum_q <= sum_d;
          r_q   <= '0;
          if (pair_q == 2'd2) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_SHIFT;
            pair_q  <= pair_q + 2'd1;
            ys_q    <= y_i[pair_q + 2'd1];
            cnt_q   <= CW'(FB - 1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = sum_q;

endmodule
`default_nettype wire

@@ design/tribonacci_mod_matrix_power.sv @@
`default_nettype none
// channel   signals                               direction
// in        in_valid_i in_ready_o term_index_i    request beat
// out       out_valid_o out_ready_i term_value_o  result beat
// cfg       cfg_valid_i cfg_ready_o cfg_index_i   register write beat
//           cfg_data_i
// one item at a time; indices 0 to 2, or a modulus below 2, bypass the matrix products
// otherwise each 3x3 matrix product runs on nine bit-serial lanes that take one
// multiplier bit per cycle; up to 2 products per exponent bit, then a final combine
// reset is asynchronous and clears control state and the config registers; config writes are always taken
module tribonacci_mod_matrix_power (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [tmp_pkg::FIELD_BITS-1:0]   term_index_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [tmp_pkg::FIELD_BITS-1:0]        term_value_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tmp_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [tmp_pkg::FIELD_BITS-1:0]   cfg_data_i
);

  localparam int MB = tmp_pkg::MODULUS_BITS;
  localparam int FB = tmp_pkg::FIELD_BITS;
  localparam int IW = tmp_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_FINAL,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [MB-1:0]   m_q;
  logic [FB-1:0]   first_q, second_q, third_q;
  logic [IW-1:0]   e_q;
  tmp_pkg::mat_t   acc_q, base_q;
  logic [FB-1:0]   res_q;
  logic            out_valid_q;
  logic [FB-1:0]   out_data_q;
  logic            start_q;

  logic [IW-1:0]   n;
  logic            in_fire;
  tmp_pkg::xvec_t  lx [3][3];
  tmp_pkg::yvec_t  ly [3][3];
  tmp_pkg::mat_t   lane_res;
  logic            lane_done;

  assign n       = term_index_i[IW-1:0];
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          lx[i][j][k] = (state_q == ST_SQR) ? base_q[i][k] : acc_q[i][k];
          ly[i][j][k] = FB'(base_q[k][j]);
        end
      end
    end
    if (state_q == ST_FINAL) begin
      ly[0][0][0] = third_q;
      ly[0][0][1] = second_q;
      ly[0][0][2] = first_q;
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      if (gi == 0 && gj == 0) begin : g_lead
        tmp_dot u_dot (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .start_i (start_q),
          .m_i     (m_q),
          .x_i     (lx[gi][gj]),
          .y_i     (ly[gi][gj]),
          .done_o  (lane_done),
          .res_o   (lane_res[gi][gj])
        );
      end else begin : g_lane
        tmp_dot u_dot (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .start_i (start_q),
          .m_i     (m_q),
          .x_i     (lx[gi][gj]),
          .y_i     (ly[gi][gj]),
          .done_o  (),
          .res_o   (lane_res[gi][gj])
        );
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      m_q         <= MB'(tmp_pkg::MODULUS_RST);
      first_q     <= '0;
      second_q    <= '0;
      third_q     <= '0;
    end else begin
      start_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tmp_pkg::REG_MODULUS: m_q      <= cfg_data_i[MB-1:0];
          tmp_pkg::REG_FIRST:   first_q  <= cfg_data_i;
          tmp_pkg::REG_SECOND:  second_q <= cfg_data_i;
          tmp_pkg::REG_THIRD:   third_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (n == IW'(0)) begin
              res_q   <= first_q;
              state_q <= ST_DONE;
            end else if (n == IW'(1)) begin
              res_q   <= second_q;
              state_q <= ST_DONE;
            end else if (n == IW'(2)) begin
              res_q   <= third_q;
              state_q <= ST_DONE;
            end else if (m_q < MB'(2)) begin
              res_q   <= '0;
              state_q <= ST_DONE;
            end else begin
              e_q     <= n - IW'(2);
              acc_q   <= tmp_pkg::identity_mat();
              base_q  <= tmp_pkg::companion_mat();
              state_q <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          start_q <= 1'b1;
          state_q <= e_q[0] ? ST_MUL : ST_SQR;
        end
        ST_MUL: begin
          if (lane_done) begin
            acc_q   <= lane_res;
            start_q <= 1'b1;
            state_q <= ((e_q >> 1) == '0) ? ST_FINAL : ST_SQR;
          end
        end
        ST_SQR: begin
          if (lane_done) begin
            base_q  <= lane_res;
            e_q     <= e_q >> 1;
            state_q <= ST_STEP;
          end
        end
        ST_FINAL: begin
          if (lane_done) begin
            res_q   <= FB'(lane_res[0][0]);
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign term_value_o = out_data_q;
  assign cfg_ready_o  = 1'b1;

`ifndef ASSERT_OFF
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done |-> (state_q == ST_MUL || state_q == ST_SQR || state_q == ST_FINAL))
    else $error("lane finished outside a product phase");
  a_lane_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done |-> (lane_res[0][0] < m_q))
    else $error("lane result not reduced");
  a_exp_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (e_q != '0))
    else $error("exponent exhausted in step");
  a_long_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && n > IW'(2) && m_q > MB'(1)) |=> (state_q == ST_STEP))
    else $error("matrix path not entered");
`endif

endmodule
`default_nettype wire

@@ tb/tribonacci_mod_matrix_power_tb.sv @@
module tribonacci_mod_matrix_power_tb;

  localparam int unsigned CYCLE_LIMIT = 30_000_000;
  localparam int unsigned SETTLE_CYCLES = 7000;
  localparam int FB = tmp_pkg::FIELD_BITS;
  localparam int MB = tmp_pkg::MODULUS_BITS;

  typedef longint unsigned mat3_t[3][3];

  typedef enum int {CHK_OK, CHK_UNEXPECTED, CHK_WRONG} chk_e;

  class term_scoreboard;
    bit [MB-1:0] modulus = MB'(tmp_pkg::MODULUS_RST);
    bit [FB-1:0] seed[3] = '{'0, '0, '0};
    bit [FB-1:0] expected_terms[$];

    function void set_reg(tmp_pkg::cfg_reg_e r, bit [FB-1:0] v);
      case (r)
        tmp_pkg::REG_MODULUS: modulus = v;
        tmp_pkg::REG_FIRST:   seed[0] = v;
        tmp_pkg::REG_SECOND:  seed[1] = v;
        tmp_pkg::REG_THIRD:   seed[2] = v;
        default: ;
      endcase
    endfunction

    function mat3_t mat_mod_mul(mat3_t a, mat3_t b);
      mat3_t r;
      longint unsigned s;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s = 0;
          for (int k = 0; k < 3; k++) s += a[i][k] * b[k][j];
          r[i][j] = s % modulus;
        end
      end
      return r;
    endfunction

    function bit [FB-1:0] tribonacci_term(bit [FB-1:0] n);
      mat3_t base, acc;
      longint unsigned e, s;
      if (n < 3) return seed[n];
      if (modulus == 0) return '0;
      base = '{'{1, 1, 1}, '{1, 0, 0}, '{0, 1, 0}};
      acc = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
      e = 64'(n) - 64'd2;
      for (int b = 0; b < tmp_pkg::INDEX_BITS; b++) begin
        if (e[b]) acc = mat_mod_mul(acc, base);
        base = mat_mod_mul(base, base);
      end
      s = acc[0][0] * seed[2] + acc[0][1] * seed[1] + acc[0][2] * seed[0];
      return FB'(s % modulus);
    endfunction

    function void note_index(bit [FB-1:0] n);
      expected_terms.push_back(tribonacci_term(n));
    endfunction

    function chk_e check_term(bit [FB-1:0] got, output bit [FB-1:0] want);
      want = '0;
      if (expected_terms.size() == 0) return CHK_UNEXPECTED;
      want = expected_terms.pop_front();
      return (got == want) ? CHK_OK : CHK_WRONG;
    endfunction

    function int pending();
      return expected_terms.size();
    endfunction
  endclass

  logic clk;
  logic rst_ni;
  logic in_valid, in_ready;
  logic [FB-1:0] term_index;
  logic out_valid, out_ready;
  logic [FB-1:0] term_value;
  logic cfg_valid, cfg_ready;
  logic [tmp_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [FB-1:0] cfg_data;

  term_scoreboard sb;
  int errors;
  int unsigned cycles;
  int send_idle_pct;
  int stall_pct;
  bit hold_go;
  int hold_left;

  tribonacci_mod_matrix_power u_top (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .term_index_i(term_index),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .term_value_o(term_value),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL tribonacci_mod_matrix_power");
      $finish;
    end
  end

  // result side
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 4000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    bit [FB-1:0] want;
    chk_e r;
    if (rst_ni && out_valid && out_ready) begin
      r = sb.check_term(term_value, want);
      if (r == CHK_UNEXPECTED)
        report($sformatf("term %0d with nothing pending", term_value));
      else if (r == CHK_WRONG)
        report($sformatf("term_value %0d, expected %0d", term_value, want));
    end
  end

  task automatic send_index(bit [FB-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    term_index <= n;
    do @(posedge clk); while (!in_ready);
    sb.note_index(n);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(tmp_pkg::cfg_reg_e r, bit [FB-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
    @(negedge clk);
  endtask

  task automatic set_all(bit [FB-1:0] m, bit [FB-1:0] a,
                         bit [FB-1:0] b, bit [FB-1:0] c);
    wait_drain();
    repeat (20) @(negedge clk);
    write_reg(tmp_pkg::REG_MODULUS, m);
    write_reg(tmp_pkg::REG_FIRST, a);
    write_reg(tmp_pkg::REG_SECOND, b);
    write_reg(tmp_pkg::REG_THIRD, c);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [FB-1:0] rand_index();
    int unsigned p;
    bit [FB-1:0] v;
    p = $urandom_range(99);
    v = FB'($urandom());
    if (p < 15) return FB'($urandom_range(0, 3));
    if (p < 80) return FB'($urandom_range(4, 400));
    if (p < 92) return v >> $urandom_range(0, 30);
    return v;
  endfunction

  function automatic bit [FB-1:0] rand_val();
    bit [FB-1:0] v;
    v = FB'($urandom());
    return ($urandom_range(1)) ? v : v >> $urandom_range(0, 30);
  endfunction

  initial begin
    bit [FB-1:0] m;
    sb = new();
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    hold_left = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    term_index = '0;
    cfg_valid = 1'b0;
    cfg_index = tmp_pkg::REG_MODULUS;
    cfg_data = '0;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // reset values, then edge indices
    send_index(0);
    send_index(3);
    set_all(1000, 1, 1, 2);
    send_index(0);
    send_index(1);
    send_index(2);
    send_index(3);
    send_index(4);
    send_index(10);
    send_index(31'h7fffffff);
    send_index(31'h40000000);
    set_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    send_index(0);
    send_index(2);
    send_index(3);
    send_index(31'h7fffffff);
    send_index(31'h2aaaaaaa);
    set_all(2, 31'h55555555, 3, 5);
    send_index(1);
    send_index(3);
    send_index(77);
    set_all(1, 7, 8, 9);
    send_index(2);
    send_index(5);
    set_all(0, 4, 5, 6);
    send_index(0);
    send_index(3);
    send_index(1000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      case ($urandom_range(3))
        0: m = FB'($urandom_range(2, 60));
        1: m = 31'h7fffffff;
        default: m = rand_val();
      endcase
      set_all(m, rand_val(), rand_val(), rand_val());
      if (ph == 2) hold_go = 1'b1;
      for (int k = 0; k < 70; k++) begin
        send_index(rand_index());
        if (ph == 5 && k == 35) wait_drain();
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && sb.pending() == 0) begin
      $display("PASS tribonacci_mod_matrix_power");
    end else begin
      $display("FAIL tribonacci_mod_matrix_power");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tmp_pkg.sv
design/tmp_dot.sv
design/tribonacci_mod_matrix_power.sv
tb/tribonacci_mod_matrix_power_tb.sv
